// File: rtl/core/opd_pkg.sv
// Package for the order-preserving deduplication block.
// Holds table sizing, field widths and the shared payload types.
// No dependencies.
package opd_pkg;

    // Table sizing.
    localparam int TABLE_DEPTH = 64;
    localparam int VALUE_WIDTH = 32;

    // Index and count widths follow from the depth.
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // Fixed widths of the beat fields.
    localparam int ITEM_W      = 32;
    localparam int COUNT_OUT_W = 7;

    typedef logic signed [ITEM_W-1:0]      t_item;
    typedef logic        [VALUE_WIDTH-1:0] t_key;
    typedef logic        [IDX_W-1:0]       t_idx;
    typedef logic        [CNT_W-1:0]       t_cnt;
    typedef logic        [COUNT_OUT_W-1:0] t_cnt_out;

endpackage

// File: rtl/core/opd_in_if.sv
// Input channel of the deduplication block: valid/ready plus one set element.
// Depends on opd_pkg.
interface opd_in_if
    import opd_pkg::*;
();
    logic  valid;
    logic  ready;
    t_item item_value;
    logic  final_item;

    modport source (output valid, output item_value, output final_item, input ready);
    modport sink   (input valid, input item_value, input final_item, output ready);
endinterface

// File: rtl/core/opd_out_if.sv
// Result channel of the deduplication block: valid/ready plus one result.
// Depends on opd_pkg.
interface opd_out_if
    import opd_pkg::*;
();
    logic     valid;
    logic     ready;
    t_item    echo_value;
    logic     first_seen;
    t_cnt_out distinct_count;
    logic     set_done;
    logic     table_full;

    modport source (output valid, output echo_value, output first_seen,
                    output distinct_count, output set_done, output table_full,
                    input ready);
    modport sink   (input valid, input echo_value, input first_seen,
                    input distinct_count, input set_done, input table_full,
                    output ready);
endinterface

// File: rtl/core/opd_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module opd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                         i_clk,
    input  logic                                         i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                             i_wr_data,
    input  logic                                         i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                             o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/order_preserving_dedup_unit.sv
// Top level of the order-preserving deduplication block.
// Depends on opd_pkg, opd_in_if, opd_out_if and opd_ram.
//
//   Channel  Direction  Beat contents
//   i_in     in         item_value (signed 32), final_item
//   o_out    out        echo_value (signed 32), first_seen, distinct_count (7),
//                       set_done, table_full
//
// A result is loaded once the scan meets the stored entry that matches, or has compared
// every stored entry without a match (with no read at all for an empty table); the store's
// single read port, one entry per cycle, sets this. The block takes no new item until the
// result is loaded, and it passes through its idle step before the next acceptance.
// Reset is synchronous and active low; it empties the table by clearing the stored count.
// A stalled output holds the block in its final step until the output register frees up.
module order_preserving_dedup_unit
    import opd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    opd_in_if.sink   i_in,
    opd_out_if.source o_out
);

    // One-hot control states: waiting for an item, scanning the store, and
    // delivering the result together with the table update.
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    t_state r_state, n_state;

    // The item under work.
    t_item r_item;
    t_key  r_key;
    logic  r_last;

    // Scan bookkeeping: r_issue is the next entry to read, r_pend says that
    // the read data now coming out of the RAM belongs to this scan.
    t_cnt  r_issue, n_issue;
    logic  r_pend,  n_pend;
    logic  r_found, n_found;

    // Number of distinct values stored for the current set.
    t_cnt  r_count, n_count;

    // Output register.
    logic     r_out_vld, n_out_vld;
    t_item    r_echo;
    logic     r_first;
    t_cnt_out r_dcount;
    logic     r_done;
    logic     r_full;

    // RAM port signals.
    logic rd_en;
    t_key rd_data;
    logic wr_en;

    logic in_take;
    logic slot_free;
    logic hit;
    logic scan_end;
    logic do_store;
    logic is_full;
    t_cnt new_count;

    assign in_take   = i_in.valid && i_in.ready;
    assign slot_free = !r_out_vld || o_out.ready;

    // A match on the entry read in the previous cycle ends the scan early.
    assign hit      = r_pend && (rd_data == r_key);
    assign scan_end = (r_issue == r_count) && !r_pend;

    // Table update, taken in the delivery step once the output slot is free.
    assign is_full   = (r_count == t_cnt'(TABLE_DEPTH));
    assign do_store  = !r_found && !is_full;
    assign new_count = r_count + t_cnt'(do_store);
    assign wr_en     = (r_state == ST_EMIT) && slot_free && do_store;

    // The write lands before any read of the next item can be issued, as the idle step
    // lies between, so the registered read always sees it and no bypass is needed.
    opd_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data (r_key),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_issue[IDX_W-1:0]),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state   = r_state;
        n_issue   = r_issue;
        n_pend    = 1'b0;
        n_found   = r_found;
        n_count   = r_count;
        n_out_vld = r_out_vld;
        rd_en     = 1'b0;

        if (r_out_vld && o_out.ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    n_state = ST_SCAN;
                    n_issue = '0;
                    n_found = 1'b0;
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    n_found = 1'b1;
                    n_state = ST_EMIT;
                end else if (scan_end) begin
                    n_found = 1'b0;
                    n_state = ST_EMIT;
                end else if (r_issue != r_count) begin
                    // Issue the next read while the previous one is compared.
                    rd_en   = 1'b1;
                    n_issue = r_issue + t_cnt'(1);
                    n_pend  = 1'b1;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_out_vld = 1'b1;
                    n_count   = r_last ? '0 : new_count;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_issue   <= '0;
            r_pend    <= 1'b0;
            r_found   <= 1'b0;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_issue   <= n_issue;
            r_pend    <= n_pend;
            r_found   <= n_found;
            r_count   <= n_count;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item <= i_in.item_value;
            r_key  <= VALUE_WIDTH'(unsigned'(i_in.item_value));
            r_last <= i_in.final_item;
        end
        if ((r_state == ST_EMIT) && slot_free) begin
            r_echo   <= r_item;
            r_first  <= do_store;
            r_dcount <= COUNT_OUT_W'(new_count);
            r_done   <= r_last;
            r_full   <= !r_found && is_full;
        end
    end

    assign i_in.ready           = (r_state == ST_IDLE);
    assign o_out.valid          = r_out_vld;
    assign o_out.echo_value     = r_echo;
    assign o_out.first_seen     = r_first;
    assign o_out.distinct_count = r_dcount;
    assign o_out.set_done       = r_done;
    assign o_out.table_full     = r_full;

    // The stored count never runs past the table depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_cnt'(TABLE_DEPTH))
        else $error("stored count exceeds table depth");

    // The scan never reads beyond the stored entries.
    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_issue <= r_count))
        else $error("scan pointer beyond stored count");

    // A delivered final item empties the table for the next set.
    a_set_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_EMIT) && slot_free && r_last) |=> (r_count == '0))
        else $error("table not emptied after final item");

    // A result is never both stored and rejected as full.
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_first && r_full))
        else $error("first_seen and table_full both set");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for order_preserving_dedup_unit: feeds sets of integer values,
// predicts each result beat from its own copy of the distinct-value table and checks them.
// Depends on opd_pkg, opd_in_if, opd_out_if and the block itself.
module tb;
    import opd_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 2;
    localparam int PHASE_ELEMS    = 385;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = TABLE_DEPTH + 16;
    localparam int MAX_REPORTS    = 10;

    localparam t_item INT_MIN = {1'b1, {(ITEM_W-1){1'b0}}};
    localparam t_item INT_MAX = {1'b0, {(ITEM_W-1){1'b1}}};

    typedef struct packed {
        t_item value;
        logic  last;
    } t_set_elem;

    typedef struct packed {
        t_item    echo;
        logic     first_seen;
        t_cnt_out count;
        logic     done;
        logic     full;
    } t_dedup_result;

    logic clk = 1'b0;
    logic rst_n;

    opd_in_if  in_ch();
    opd_out_if out_ch();

    order_preserving_dedup_unit uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Shadow of the distinct-value table for the set in progress.
    t_key          dedup_table [TABLE_DEPTH];
    int            table_fill;
    t_set_elem     pending_elems [$];
    t_dedup_result awaited_results [$];

    int send_idle_pct;
    int recv_stall_pct;
    int hold_requests;
    int holds_served;
    int hold_left;
    int idle_cycles;
    int error_count;
    int elems_sent;
    int results_seen;
    int sets_closed;
    int first_seen_total;
    int dup_total;
    int full_total;

    always begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Works out the result of one accepted element and updates the shadow table.
    function automatic t_dedup_result predict_dedup(input t_item value, input logic last);
        t_dedup_result res;
        t_key          key;
        logic          found;
        key   = t_key'(value);
        found = 1'b0;
        for (int i = 0; i < table_fill; i++) begin
            if (dedup_table[i] == key) begin
                found = 1'b1;
            end
        end
        res.echo       = value;
        res.first_seen = 1'b0;
        res.full       = 1'b0;
        res.done       = last;
        if (!found) begin
            if (table_fill < TABLE_DEPTH) begin
                dedup_table[table_fill] = key;
                table_fill++;
                res.first_seen = 1'b1;
                first_seen_total++;
            end else begin
                res.full = 1'b1;
                full_total++;
            end
        end else begin
            dup_total++;
        end
        res.count = t_cnt_out'(table_fill);
        if (last) begin
            table_fill = 0;
            sets_closed++;
        end
        return res;
    endfunction

    function automatic t_item fresh_value();
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(3))
                    0:       return INT_MIN;
                    1:       return INT_MAX;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            // A small pool, so that values recur from one set to the next.
            1:       return t_item'($urandom_range(7));
            default: return t_item'($urandom);
        endcase
    endfunction

    task automatic push_elem(input t_item value, input logic last);
        t_set_elem e;
        e.value = value;
        e.last  = last;
        pending_elems.push_back(e);
    endtask

    // One set of len elements; each after the first repeats an earlier one of the set with a chance of dup_pct percent.
    task automatic add_set(input int len, input int dup_pct);
        t_item used [$];
        t_item v;
        for (int j = 0; j < len; j++) begin
            if (used.size() > 0 && $urandom_range(99) < dup_pct) begin
                v = used[$urandom_range(used.size() - 1)];
            end else begin
                v = fresh_value();
            end
            used.push_back(v);
            push_elem(v, j == len - 1);
        end
    endtask

    // Fills the table exactly, then offers a value that cannot be stored, a repeat of a
    // stored one, the refused value again and a new value as the final element.
    task automatic add_fill_set();
        t_item base;
        t_item step;
        base = t_item'($urandom);
        step = t_item'($urandom | 1);
        for (int j = 0; j < TABLE_DEPTH; j++) begin
            push_elem(base + j * step, 1'b0);
        end
        push_elem(base + TABLE_DEPTH * step, 1'b0);
        push_elem(base, 1'b0);
        push_elem(base + TABLE_DEPTH * step, 1'b0);
        push_elem(base + (TABLE_DEPTH + 1) * step, 1'b1);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (pending_elems.size() != 0 || in_ch.valid || awaited_results.size() != 0) begin
            @(negedge clk);
        end
    endtask

    // Driver: offers the next element when the channel is free, idling at random for send_idle_pct percent of them.
    always @(posedge clk) begin
        t_set_elem next_elem;
        if (!rst_n) begin
            in_ch.valid      <= 1'b0;
            in_ch.item_value <= '0;
            in_ch.final_item <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                awaited_results.push_back(predict_dedup(in_ch.item_value, in_ch.final_item));
                elems_sent++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_elems.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_elem = pending_elems.pop_front();
                    in_ch.valid      <= 1'b1;
                    in_ch.item_value <= next_elem.value;
                    in_ch.final_item <= next_elem.last;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result beat and drives ready, including the long hold-off.
    always @(posedge clk) begin
        t_dedup_result got;
        t_dedup_result want;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            hold_left    <= 0;
            holds_served <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got.echo       = out_ch.echo_value;
                got.first_seen = out_ch.first_seen;
                got.count      = out_ch.distinct_count;
                got.done       = out_ch.set_done;
                got.full       = out_ch.table_full;
                results_seen++;
                if (awaited_results.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("Result beat %0d arrived with nothing outstanding: value %h",
                                 results_seen, got.echo);
                    end
                end else begin
                    want = awaited_results.pop_front();
                    if (got !== want) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS) begin
                            $display("Beat %0d mismatch: exp value %h first %b count %0d",
                                     results_seen, want.echo, want.first_seen, want.count);
                            $display("    exp done %b full %b", want.done, want.full);
                            $display("    got value %h first %b count %0d done %b full %b",
                                     got.echo, got.first_seen, got.count, got.done,
                                     got.full);
                        end
                    end
                end
            end
            if (hold_requests != holds_served) begin
                holds_served <= holds_served + 1;
                hold_left    <= HOLD_CYCLES;
                out_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left    <= hold_left - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: ends the run when no beat moves on either channel for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired after %0d cycles without a beat", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int send_pct [4];
        int recv_pct [4];
        int phase_elems;
        int len;
        send_pct = '{0, 76, 0, 14};
        recv_pct = '{0, 0, 76, 14};
        rst_n            = 1'b0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        hold_requests    = 0;
        table_fill       = 0;
        error_count      = 0;
        elems_sent       = 0;
        results_seen     = 0;
        sets_closed      = 0;
        first_seen_total = 0;
        dup_total        = 0;
        full_total       = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Extremes, repeats and a repeated final element.
        push_elem(INT_MIN, 1'b0);
        push_elem(INT_MAX, 1'b0);
        push_elem('0, 1'b0);
        push_elem('1, 1'b0);
        push_elem(INT_MIN, 1'b0);
        push_elem(t_item'(1), 1'b0);
        push_elem(t_item'(32'hAAAA_AAAA), 1'b0);
        push_elem(t_item'(32'h5555_5555), 1'b0);
        push_elem(INT_MAX, 1'b1);
        // A one-element set: the table must have emptied.
        push_elem('0, 1'b1);
        // A new value as the final element.
        push_elem(INT_MIN, 1'b0);
        push_elem(INT_MIN, 1'b0);
        push_elem('1, 1'b1);
        // One value three times: a new entry, then nothing but repeats.
        push_elem(t_item'(7), 1'b0);
        push_elem(t_item'(7), 1'b0);
        push_elem(t_item'(7), 1'b1);
        wait_drained();

        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = send_pct[p];
            recv_stall_pct = recv_pct[p];
            phase_elems    = 0;
            if (p == 0) begin
                add_fill_set();
                phase_elems += TABLE_DEPTH + 4;
            end
            while (phase_elems < PHASE_ELEMS) begin
                case ($urandom_range(11))
                    0: begin
                        // Long sets that often run the table to its limit.
                        len = TABLE_DEPTH - 4 + $urandom_range(16);
                        add_set(len, 5);
                    end
                    1: begin
                        len = $urandom_range(40, 16);
                        add_set(len, $urandom_range(60, 10));
                    end
                    default: begin
                        len = $urandom_range(12, 1);
                        add_set(len, $urandom_range(70, 0));
                    end
                endcase
                phase_elems += len;
            end
            // With the sender never idle, a long receiver hold-off backs the block up.
            if (p == 0) begin
                hold_requests++;
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (awaited_results.size() != 0) begin
            error_count += awaited_results.size();
            $display("%0d expected results never arrived", awaited_results.size());
        end
        $display("Sent %0d elements in %0d sets: %0d first-seen, %0d repeats, %0d refused full.",
                 elems_sent, sets_closed, first_seen_total, dup_total, full_total);
        $display("Checked %0d result beats under four idling patterns; %0d failures.",
                 results_seen, error_count);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/opd_pkg.sv
rtl/core/opd_in_if.sv
rtl/core/opd_out_if.sv
rtl/core/opd_ram.sv
rtl/core/order_preserving_dedup_unit.sv
tb/sv/tb.sv
